/* src/prp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prp_pkg
// Types and constants shared by the Poiseuille path resistance core.
// ----------------------------------------------------------------------------
package prp_pkg;

  localparam int PosW    = 20;
  localparam int RadW    = 16;
  localparam int SpW     = 16;
  localparam int SpFracW = 12;
  localparam int FcW     = 32;
  localparam int ResW    = 48;
  localparam int LenW    = 32;
  localparam int TotW    = 32;
  localparam int CntW    = 16;
  localparam int CfgIdxW = 8;
  localparam int CfgDatW = 32;

  localparam int ProdW = PosW + SpW - 10;
  localparam int SqW   = 2 * ProdW + 2;
  localparam int RootW = SqW / 2;
  localparam int SumW  = RadW + 1;
  localparam int DivNW = 64;
  localparam int DivDW = 2 * SumW;
  localparam int DivCntW = $clog2(DivNW + 1);

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [CfgIdxW-1:0] RegFlow = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegSpX  = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegSpY  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegSpZ  = CfgIdxW'(3);

  localparam logic [SpW-1:0]  SpacingReset = SpW'(4096);
  localparam logic [ResW-1:0] ResMax = '1;
  localparam logic [RadW-1:0] RadMax = '1;
  localparam logic [CntW-1:0] CntMax = '1;

  typedef struct packed {
    logic [FcW-1:0] flow_coefficient;
    logic [SpW-1:0] spacing_x;
    logic [SpW-1:0] spacing_y;
    logic [SpW-1:0] spacing_z;
  } cfg_t;

  typedef struct packed {
    logic [PosW-1:0] dx;
    logic [PosW-1:0] dy;
    logic [PosW-1:0] dz;
    logic [RadW-1:0] radius;
    logic [RadW-1:0] prev_radius;
    logic            first;
    logic            last;
  } seg_cmd_t;

  typedef struct packed {
    logic             start;
    logic [DivNW-1:0] dividend;
    logic [DivDW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DivNW-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

/* src/prp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prp_if
// Channel interfaces of the core: point items, result items and register writes.
// ----------------------------------------------------------------------------
interface prp_in_if import prp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PosW-1:0] pos_x;
  logic [PosW-1:0] pos_y;
  logic [PosW-1:0] pos_z;
  logic [RadW-1:0] radius;
  logic            first_point;
  logic            last_point;
  modport source(output valid, pos_x, pos_y, pos_z, radius, first_point, last_point,
                 input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, radius, first_point, last_point,
               output ready);
endinterface

interface prp_out_if import prp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RadW-1:0] index_radius;
  logic [ResW-1:0] resistance;
  logic [LenW-1:0] path_length;
  logic [RadW-1:0] min_radius;
  logic [RadW-1:0] max_radius;
  logic [RadW-1:0] mean_radius;
  logic            tube_done;
  logic            zero_radius_flag;
  modport source(output valid, index_radius, resistance, path_length, min_radius,
                 max_radius, mean_radius, tube_done, zero_radius_flag, input ready);
  modport sink(input valid, index_radius, resistance, path_length, min_radius,
               max_radius, mean_radius, tube_done, zero_radius_flag, output ready);
endinterface

interface prp_cfg_if import prp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/prp_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prp_front
// Accepts point items, keeps the previous point and forms segment commands.
// ----------------------------------------------------------------------------
module prp_front import prp_pkg::*; #(
  parameter int DIMENSION = 3
) (
  input  logic     clk,
  input  logic     rst_n,
  prp_in_if.sink   in_ch,
  input  logic     q_full,
  output logic     q_push,
  output seg_cmd_t q_cmd
);

  logic [PosW-1:0] prev_x_r, prev_y_r, prev_z_r;
  logic [RadW-1:0] prev_rad_r;

  function automatic logic [PosW-1:0] abs_diff(logic [PosW-1:0] a, logic [PosW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_cmd.dx          = abs_diff(in_ch.pos_x, prev_x_r);
    q_cmd.dy          = abs_diff(in_ch.pos_y, prev_y_r);
    q_cmd.dz          = (DIMENSION > 2) ? abs_diff(in_ch.pos_z, prev_z_r) : '0;
    q_cmd.radius      = in_ch.radius;
    q_cmd.prev_radius = prev_rad_r;
    q_cmd.first       = in_ch.first_point;
    q_cmd.last        = in_ch.last_point;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r   <= '0;
      prev_y_r   <= '0;
      prev_z_r   <= '0;
      prev_rad_r <= '0;
    end else if (q_push) begin
      prev_x_r   <= in_ch.pos_x;
      prev_y_r   <= in_ch.pos_y;
      prev_z_r   <= in_ch.pos_z;
      prev_rad_r <= in_ch.radius;
    end
  end

endmodule
`default_nettype wire

/* src/prp_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prp_queue
// Short queue of segment commands between the front and the back.
// ----------------------------------------------------------------------------
module prp_queue import prp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  seg_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     pop_valid,
  output seg_cmd_t pop_cmd
);

  seg_cmd_t         mem_r [QDepth];
  logic [QPtrW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCntW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCntW'(QDepth));
  assign pop_valid = (cnt_r != '0);
  assign pop_cmd   = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + QCntW'(push) - QCntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

/* src/prp_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prp_divider
// Shared restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prp_divider import prp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic               busy_r, busy_nxt, done_r, done_nxt;
  logic [DivCntW-1:0] cnt_r, cnt_nxt;
  logic [DivNW-1:0]   quo_r, quo_nxt;
  logic [DivDW-1:0]   rem_r, rem_nxt, dsr_r, dsr_nxt;
  logic [DivDW:0]     shifted, diff;

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    shifted  = {rem_r, quo_r[DivNW-1]};
    diff     = shifted - {1'b0, dsr_r};
    if (busy_r) begin
      if (shifted >= {1'b0, dsr_r}) begin
        rem_nxt = diff[DivDW-1:0];
        quo_nxt = {quo_r[DivNW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DivDW-1:0];
        quo_nxt = {quo_r[DivNW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DivCntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DivCntW'(DivNW);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

endmodule
`default_nettype wire

/* src/prp_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// prp_back
// Sequencer that works out one segment per command and holds the tube totals.
// ----------------------------------------------------------------------------
module prp_back import prp_pkg::*; #(
  parameter int DIMENSION = 3
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     q_valid,
  input  seg_cmd_t q_cmd,
  output logic     q_pop,
  output div_req_t div_req,
  input  div_rsp_t div_rsp,
  prp_out_if.source out_ch
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SCALE  = 4'd1;
  localparam logic [3:0] ST_SQUARE = 4'd2;
  localparam logic [3:0] ST_ROOT   = 4'd3;
  localparam logic [3:0] ST_SQR_S  = 4'd4;
  localparam logic [3:0] ST_MUL_FC = 4'd5;
  localparam logic [3:0] ST_DIV1   = 4'd6;
  localparam logic [3:0] ST_DIV2   = 4'd7;
  localparam logic [3:0] ST_IRAD   = 4'd8;
  localparam logic [3:0] ST_MEAN   = 4'd9;
  localparam logic [3:0] ST_OUT    = 4'd10;

  localparam logic [1:0] LastAxis = 2'(DIMENSION - 1);

  logic [3:0]       state_r, state_nxt;
  seg_cmd_t         cmd_r, cmd_nxt;
  logic [1:0]       axis_r, axis_nxt;
  logic [ProdW-1:0] p_r, p_nxt;
  logic [SqW-1:0]   sq_r, sq_nxt, v_r, v_nxt, rt_r, rt_nxt, bit_r, bit_nxt;
  logic [RootW-1:0] dl_r, dl_nxt;
  logic [SumW-1:0]  s_r, s_nxt;
  logic [DivDW-1:0] s2_r, s2_nxt;
  logic [DivNW-1:0] num_r, num_nxt, q1_r, q1_nxt;
  logic [ResW-1:0]  res_r, res_nxt;
  logic [LenW-1:0]  len_r, len_nxt;
  logic [RadW-1:0]  min_r, min_nxt, max_r, max_nxt, irad_r, irad_nxt, mean_r, mean_nxt;
  logic [TotW-1:0]  tot_r, tot_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             zero_r, zero_nxt, issued_r, issued_nxt, ov_r, ov_nxt;
  logic [RadW-1:0]  oi_r, oi_nxt, omin_r, omin_nxt, omax_r, omax_nxt, omean_r, omean_nxt;
  logic [ResW-1:0]  ores_r, ores_nxt;
  logic [LenW-1:0]  olen_r, olen_nxt;
  logic             odone_r, odone_nxt, ozero_r, ozero_nxt;

  logic [PosW-1:0]      d_sel;
  logic [SpW-1:0]       sp_sel;
  logic [PosW+SpW-1:0]  mul_ax;
  logic [2*ProdW-1:0]   sq_term;
  logic [SqW-1:0]       sq_sum, root_try;
  logic [TotW:0]        tot_sum;
  logic [LenW:0]        len_sum;
  logic [FcW+RootW-1:0] fc_prod;
  logic [DivNW-1:0]     res_room;
  logic [ResW:0]        res_sum;

  assign out_ch.valid            = ov_r;
  assign out_ch.index_radius     = oi_r;
  assign out_ch.resistance       = ores_r;
  assign out_ch.path_length      = olen_r;
  assign out_ch.min_radius       = omin_r;
  assign out_ch.max_radius       = omax_r;
  assign out_ch.mean_radius      = omean_r;
  assign out_ch.tube_done        = odone_r;
  assign out_ch.zero_radius_flag = ozero_r;

  always_comb begin
    unique case (axis_r)
      2'd0:    begin d_sel = cmd_r.dx; sp_sel = cfg.spacing_x; end
      2'd1:    begin d_sel = cmd_r.dy; sp_sel = cfg.spacing_y; end
      default: begin d_sel = cmd_r.dz; sp_sel = cfg.spacing_z; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;  cmd_nxt = cmd_r;    axis_nxt = axis_r;  p_nxt = p_r;
    sq_nxt = sq_r;        v_nxt = v_r;        rt_nxt = rt_r;      bit_nxt = bit_r;
    dl_nxt = dl_r;        s_nxt = s_r;        s2_nxt = s2_r;      num_nxt = num_r;
    q1_nxt = q1_r;        res_nxt = res_r;    len_nxt = len_r;    min_nxt = min_r;
    max_nxt = max_r;      irad_nxt = irad_r;  mean_nxt = mean_r;  tot_nxt = tot_r;
    cnt_nxt = cnt_r;      zero_nxt = zero_r;  issued_nxt = issued_r;
    oi_nxt = oi_r;        ores_nxt = ores_r;  olen_nxt = olen_r;  omin_nxt = omin_r;
    omax_nxt = omax_r;    omean_nxt = omean_r; odone_nxt = odone_r; ozero_nxt = ozero_r;
    ov_nxt = ov_r && !out_ch.ready;
    q_pop  = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = num_r;
    div_req.divisor  = s2_r;

    mul_ax   = d_sel * sp_sel;
    sq_term  = p_r * p_r;
    sq_sum   = sq_r + SqW'(sq_term);
    root_try = rt_r + bit_r;
    tot_sum  = {1'b0, tot_r} + (TotW+1)'(q_cmd.radius);
    len_sum  = {1'b0, len_r} + (LenW+1)'((dl_r + RootW'(2)) >> 2);
    fc_prod  = cfg.flow_coefficient * dl_r;
    res_room = DivNW'(ResMax - res_r);
    res_sum  = {1'b0, res_r} + (ResW+1)'(div_rsp.quotient[ResW-1:0]);

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          s_nxt   = {1'b0, q_cmd.radius} + {1'b0, q_cmd.prev_radius};
          if (q_cmd.first) begin
            res_nxt   = '0;
            len_nxt   = '0;
            min_nxt   = q_cmd.radius;
            max_nxt   = q_cmd.radius;
            tot_nxt   = TotW'(q_cmd.radius);
            cnt_nxt   = CntW'(1);
            zero_nxt  = 1'b0;
            state_nxt = ST_IRAD;
          end else begin
            if (q_cmd.radius < min_r) min_nxt = q_cmd.radius;
            if (q_cmd.radius > max_r) max_nxt = q_cmd.radius;
            tot_nxt   = tot_sum[TotW] ? '1 : tot_sum[TotW-1:0];
            cnt_nxt   = (cnt_r == CntMax) ? cnt_r : cnt_r + 1'b1;
            sq_nxt    = '0;
            axis_nxt  = '0;
            state_nxt = ST_SCALE;
          end
        end
      end
      ST_SCALE: begin
        p_nxt     = mul_ax[ProdW+9:10];
        state_nxt = ST_SQUARE;
      end
      ST_SQUARE: begin
        sq_nxt = sq_sum;
        if (axis_r == LastAxis) begin
          v_nxt     = sq_sum;
          rt_nxt    = '0;
          bit_nxt   = SqW'(1) << (SqW - 2);
          state_nxt = ST_ROOT;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = ST_SCALE;
        end
      end
      ST_ROOT: begin
        if (v_r >= root_try) begin
          v_nxt  = v_r - root_try;
          rt_nxt = (rt_r >> 1) + bit_r;
        end else begin
          rt_nxt = rt_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          dl_nxt    = rt_nxt[RootW-1:0];
          state_nxt = ST_SQR_S;
        end
      end
      ST_SQR_S: begin
        len_nxt = len_sum[LenW] ? '1 : len_sum[LenW-1:0];
        s2_nxt  = s_r * s_r;
        if (s_r == '0) begin
          res_nxt   = ResMax;
          zero_nxt  = 1'b1;
          state_nxt = ST_IRAD;
        end else begin
          state_nxt = ST_MUL_FC;
        end
      end
      ST_MUL_FC: begin
        num_nxt   = DivNW'({fc_prod, 2'b00});
        state_nxt = ST_DIV1;
      end
      ST_DIV1: begin
        if (!issued_r) begin
          div_req.start = 1'b1;
          issued_nxt    = 1'b1;
        end else if (div_rsp.done) begin
          q1_nxt     = div_rsp.quotient;
          issued_nxt = 1'b0;
          state_nxt  = ST_DIV2;
        end
      end
      ST_DIV2: begin
        div_req.dividend = q1_r;
        if (!issued_r) begin
          div_req.start = 1'b1;
          issued_nxt    = 1'b1;
        end else if (div_rsp.done) begin
          res_nxt    = (res_room <= div_rsp.quotient) ? ResMax : res_sum[ResW-1:0];
          issued_nxt = 1'b0;
          state_nxt  = ST_IRAD;
        end
      end
      ST_IRAD: begin
        div_req.dividend = DivNW'({cmd_r.radius, {SpFracW{1'b0}}});
        div_req.divisor  = DivDW'(cfg.spacing_x);
        if (cfg.spacing_x == '0) begin
          irad_nxt  = RadMax;
          state_nxt = ST_MEAN;
        end else if (!issued_r) begin
          div_req.start = 1'b1;
          issued_nxt    = 1'b1;
        end else if (div_rsp.done) begin
          irad_nxt   = (|div_rsp.quotient[DivNW-1:RadW]) ? RadMax
                                                          : div_rsp.quotient[RadW-1:0];
          issued_nxt = 1'b0;
          state_nxt  = ST_MEAN;
        end
      end
      ST_MEAN: begin
        div_req.dividend = DivNW'(tot_r);
        div_req.divisor  = DivDW'(cnt_r);
        if (!cmd_r.last || cnt_r == '0) begin
          mean_nxt  = '0;
          state_nxt = ST_OUT;
        end else if (!issued_r) begin
          div_req.start = 1'b1;
          issued_nxt    = 1'b1;
        end else if (div_rsp.done) begin
          mean_nxt   = div_rsp.quotient[RadW-1:0];
          issued_nxt = 1'b0;
          state_nxt  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          oi_nxt    = irad_r;
          ores_nxt  = res_r;
          olen_nxt  = len_r;
          omin_nxt  = min_r;
          omax_nxt  = max_r;
          omean_nxt = mean_r;
          odone_nxt = cmd_r.last;
          ozero_nxt = zero_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      issued_r <= 1'b0;
      ov_r     <= 1'b0;
      res_r    <= '0;
      len_r    <= '0;
      min_r    <= '0;
      max_r    <= '0;
      tot_r    <= '0;
      cnt_r    <= '0;
      zero_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
      ov_r     <= ov_nxt;
      res_r    <= res_nxt;
      len_r    <= len_nxt;
      min_r    <= min_nxt;
      max_r    <= max_nxt;
      tot_r    <= tot_nxt;
      cnt_r    <= cnt_nxt;
      zero_r   <= zero_nxt;
    end
    cmd_r   <= cmd_nxt;   axis_r  <= axis_nxt;  p_r     <= p_nxt;     sq_r   <= sq_nxt;
    v_r     <= v_nxt;     rt_r    <= rt_nxt;    bit_r   <= bit_nxt;   dl_r   <= dl_nxt;
    s_r     <= s_nxt;     s2_r    <= s2_nxt;    num_r   <= num_nxt;   q1_r   <= q1_nxt;
    irad_r  <= irad_nxt;  mean_r  <= mean_nxt;  oi_r    <= oi_nxt;    ores_r <= ores_nxt;
    olen_r  <= olen_nxt;  omin_r  <= omin_nxt;  omax_r  <= omax_nxt;
    omean_r <= omean_nxt; odone_r <= odone_nxt; ozero_r <= ozero_nxt;
  end

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy) else $error("divider started while busy");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("queue popped while empty");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    min_r <= max_r) else $error("smallest radius exceeds largest radius");

  a_zero_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(zero_r) |-> (s_r == '0)) else $error("zero flag set with nonzero radius sum");

endmodule
`default_nettype wire

/* src/poiseuille_path_resistance_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// poiseuille_path_resistance_core
// Accumulates Poiseuille resistance, length and radius statistics along a tube.
// ----------------------------------------------------------------------------
// Every item takes longer when it also closes a tube, as the mean radius is then
// divided out on the shared divider, one quotient bit per cycle over 64 bits.
// One item is worked at a time; a two-entry queue and the output register let
// input and output stall independently. Synchronous active-low reset clears all
// accumulators and restores the register defaults.
module poiseuille_path_resistance_core import prp_pkg::*; #(
  parameter int DIMENSION = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  prp_in_if.sink     in_ch,
  prp_out_if.source  out_ch,
  prp_cfg_if.sink    cfg_ch
);

  cfg_t     cfg_r, cfg_nxt;
  logic     q_push, q_full, q_pop, q_valid;
  seg_cmd_t push_cmd, pop_cmd;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        RegFlow: cfg_nxt.flow_coefficient = cfg_ch.data[FcW-1:0];
        RegSpX:  cfg_nxt.spacing_x        = cfg_ch.data[SpW-1:0];
        RegSpY:  cfg_nxt.spacing_y        = cfg_ch.data[SpW-1:0];
        RegSpZ:  cfg_nxt.spacing_z        = cfg_ch.data[SpW-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flow_coefficient <= '0;
      cfg_r.spacing_x        <= SpacingReset;
      cfg_r.spacing_y        <= SpacingReset;
      cfg_r.spacing_z        <= SpacingReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  prp_front #(.DIMENSION(DIMENSION)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  prp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (pop_cmd)
  );

  prp_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  prp_back #(.DIMENSION(DIMENSION)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_cmd   (pop_cmd),
    .q_pop   (q_pop),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

/* tb/poiseuille_path_resistance_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// poiseuille_path_resistance_core_test
// Drives centreline points through the core and checks every result item
// against a behavioural model of the segment length, resistance and radius
// statistics, under several register settings and random idling.
// ----------------------------------------------------------------------------
module poiseuille_path_resistance_core_test;
  import prp_pkg::*;

  typedef struct {
    logic [RadW-1:0] index_radius;
    logic [ResW-1:0] resistance;
    logic [LenW-1:0] path_length;
    logic [RadW-1:0] min_radius;
    logic [RadW-1:0] max_radius;
    logic [RadW-1:0] mean_radius;
    logic            tube_done;
    logic            zero_radius_flag;
  } tube_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  prp_in_if  in_ch ();
  prp_out_if out_ch ();
  prp_cfg_if cfg_ch ();

  poiseuille_path_resistance_core #(.DIMENSION(3)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always #1 clk = ~clk;

  // Model state.
  logic [FcW-1:0]  m_flow;
  logic [SpW-1:0]  m_spx, m_spy, m_spz;
  logic [PosW-1:0] m_px, m_py, m_pz;
  logic [RadW-1:0] m_prad, m_rmin, m_rmax;
  logic [ResW-1:0] m_res;
  logic [LenW-1:0] m_len;
  logic [TotW-1:0] m_rtot;
  logic [CntW-1:0] m_cnt;
  logic            m_zero;

  tube_result_t pending_results[$];
  int  errors = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  recv_hold = 1'b0;
  int  idle_cycles = 0;

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] axis_sq(logic [PosW-1:0] a, logic [PosW-1:0] b,
                                          logic [SpW-1:0] sp);
    logic [63:0] d, p;
    d = (a > b) ? 64'(a - b) : 64'(b - a);
    p = (d * sp) >> 10;
    return p * p;
  endfunction

  task automatic predict_point(logic [PosW-1:0] px, logic [PosW-1:0] py,
                               logic [PosW-1:0] pz, logic [RadW-1:0] rad,
                               logic first, logic last);
    tube_result_t r;
    logic [63:0] sq, dl, inc, s, s2, q, ir, tot;
    if (first) begin
      m_res = '0; m_len = '0; m_rmin = rad; m_rmax = rad;
      m_rtot = TotW'(rad); m_cnt = CntW'(1); m_zero = 1'b0;
    end else begin
      if (rad < m_rmin) m_rmin = rad;
      if (rad > m_rmax) m_rmax = rad;
      tot = 64'(m_rtot) + 64'(rad);
      m_rtot = (tot > 64'hFFFF_FFFF) ? '1 : tot[31:0];
      if (m_cnt != CntMax) m_cnt = m_cnt + 1'b1;
      sq = axis_sq(px, m_px, m_spx) + axis_sq(py, m_py, m_spy)
         + axis_sq(pz, m_pz, m_spz);
      dl = isqrt(sq);
      inc = (dl + 64'd2) >> 2;
      tot = 64'(m_len) + inc;
      m_len = (tot > 64'hFFFF_FFFF) ? '1 : tot[31:0];
      s = 64'(rad) + 64'(m_prad);
      if (s == 0) begin
        m_res = ResMax;
        m_zero = 1'b1;
      end else begin
        s2 = s * s;
        q = ((64'(m_flow) * dl * 64'd4) / s2) / s2;
        m_res = (64'(ResMax) - 64'(m_res) <= q) ? ResMax : m_res + q[47:0];
      end
    end
    m_px = px; m_py = py; m_pz = pz; m_prad = rad;
    if (m_spx == 0) ir = 64'hFFFF;
    else begin
      ir = (64'(rad) * 64'd4096) / 64'(m_spx);
      if (ir > 64'hFFFF) ir = 64'hFFFF;
    end
    r.index_radius = ir[15:0];
    r.resistance = m_res;
    r.path_length = m_len;
    r.min_radius = m_rmin;
    r.max_radius = m_rmax;
    r.mean_radius = (last && m_cnt != 0) ? RadW'(m_rtot / TotW'(m_cnt)) : '0;
    r.tube_done = last;
    r.zero_radius_flag = m_zero;
    pending_results = {pending_results, r};
  endtask

  task automatic send_point(logic [PosW-1:0] px, logic [PosW-1:0] py,
                            logic [PosW-1:0] pz, logic [RadW-1:0] rad,
                            logic first, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pos_x <= px; in_ch.pos_y <= py; in_ch.pos_z <= pz;
    in_ch.radius <= rad; in_ch.first_point <= first; in_ch.last_point <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_point(px, py, pz, rad, first, last);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      RegFlow: m_flow = val;
      RegSpX:  m_spx = val[15:0];
      RegSpY:  m_spy = val[15:0];
      RegSpZ:  m_spz = val[15:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic drain;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  task automatic configure(logic [31:0] flow, logic [15:0] sx, logic [15:0] sy,
                           logic [15:0] sz);
    drain();
    write_reg(RegFlow, flow);
    write_reg(RegSpX, 32'(sx));
    write_reg(RegSpY, 32'(sy));
    write_reg(RegSpZ, 32'(sz));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_directed;
    send_point(20'd100, 20'd0, 20'd0, 16'd256, 1'b0, 1'b0);
    send_point(20'd0, 20'd0, 20'd0, 16'd0, 1'b1, 1'b1);
    send_point(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 1'b1, 1'b0);
    send_point(20'd0, 20'd0, 20'd0, 16'hFFFF, 1'b0, 1'b0);
    send_point(20'hFFFFF, 20'd0, 20'hFFFFF, 16'd1, 1'b0, 1'b1);
    send_point(20'd512, 20'd512, 20'd512, 16'd0, 1'b1, 1'b0);
    send_point(20'd768, 20'd256, 20'd512, 16'd0, 1'b0, 1'b0);
    send_point(20'd1024, 20'd256, 20'd512, 16'd512, 1'b0, 1'b1);
    send_point(20'd1024, 20'd256, 20'd512, 16'd512, 1'b0, 1'b1);
    send_point(20'd10, 20'd20, 20'd30, 16'd1, 1'b1, 1'b0);
    send_point(20'd11, 20'd21, 20'd31, 16'd1, 1'b0, 1'b0);
    send_point(20'd12, 20'd22, 20'd32, 16'd1, 1'b0, 1'b1);
    in_ch.valid <= 1'b0;
  endtask

  task automatic random_tubes(int n);
    int k, len, i;
    k = 0;
    while (k < n) begin
      if ($urandom_range(9) == 0) begin
        send_point(20'($urandom), 20'($urandom), 20'($urandom), 16'($urandom),
                   1'($urandom), 1'($urandom));
        k++;
      end else begin
        len = $urandom_range(8, 1);
        for (i = 0; i < len; i++) begin
          send_point(20'(m_px + $urandom_range(2048) - 1024 * (m_px > 1024)),
                     20'(m_py + $urandom_range(2048) - 1024 * (m_py > 1024)),
                     ($urandom_range(19) == 0) ? 20'($urandom) :
                       20'(m_pz + $urandom_range(1024)),
                     ($urandom_range(9) == 0) ? 16'($urandom) :
                       16'($urandom_range(4096, 0)),
                     i == 0, i == len - 1);
        end
        k += len;
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic test_backpressure;
    drain();
    recv_hold = 1'b1;
    fork
      begin
        repeat (600) @(negedge clk);
        recv_hold = 1'b0;
      end
      random_tubes(12);
    join
    drain();
  endtask

  task automatic test_random_settings;
    send_idle_pct = 30; recv_idle_pct = 58;
    configure(32'hFFFF_FFFF, 16'd4096, 16'd4096, 16'd4096);
    random_tubes(350);
    send_idle_pct = 58; recv_idle_pct = 30;
    configure(32'd1, 16'd1, 16'hFFFF, 16'd1);
    random_tubes(300);
    send_idle_pct = 0; recv_idle_pct = 0;
    configure(32'($urandom), 16'hFFFF, 16'd1, 16'hFFFF);
    random_tubes(300);
    configure(32'h0012_3456, 16'd0, 16'd0, 16'd0);
    random_tubes(300);
    configure(32'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_tubes(350);
  endtask

  always @(negedge clk) begin
    out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready || out_ch.valid && out_ch.ready
        || (pending_results.size() == 0 && !in_ch.valid))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    tube_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item", $time);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_ch.index_radius !== e.index_radius || out_ch.resistance !== e.resistance
            || out_ch.path_length !== e.path_length
            || out_ch.min_radius !== e.min_radius || out_ch.max_radius !== e.max_radius
            || out_ch.mean_radius !== e.mean_radius || out_ch.tube_done !== e.tube_done
            || out_ch.zero_radius_flag !== e.zero_radius_flag) begin
          $display("%0t: mismatch expected ir=%h res=%h len=%h min=%h max=%h mean=%h d=%b z=%b",
                   $time, e.index_radius, e.resistance, e.path_length, e.min_radius,
                   e.max_radius, e.mean_radius, e.tube_done, e.zero_radius_flag);
          $display("%0t: mismatch actual   ir=%h res=%h len=%h min=%h max=%h mean=%h d=%b z=%b",
                   $time, out_ch.index_radius, out_ch.resistance, out_ch.path_length,
                   out_ch.min_radius, out_ch.max_radius, out_ch.mean_radius,
                   out_ch.tube_done, out_ch.zero_radius_flag);
          errors++;
        end
      end
    end
  end

  initial begin
    m_flow = '0; m_spx = SpacingReset; m_spy = SpacingReset; m_spz = SpacingReset;
    m_px = '0; m_py = '0; m_pz = '0; m_prad = '0; m_rmin = '0; m_rmax = '0;
    m_res = '0; m_len = '0; m_rtot = '0; m_cnt = '0; m_zero = 1'b0;
    in_ch.valid = 1'b0; in_ch.pos_x = '0; in_ch.pos_y = '0; in_ch.pos_z = '0;
    in_ch.radius = '0; in_ch.first_point = 1'b0; in_ch.last_point = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    configure(32'd5000, 16'd4096, 16'd2048, 16'd8192);
    test_directed();
    test_backpressure();
    test_random_settings();
    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
src/prp_pkg.sv
src/prp_if.sv
src/prp_front.sv
src/prp_queue.sv
src/prp_divider.sv
src/prp_back.sv
src/poiseuille_path_resistance_core.sv
tb/poiseuille_path_resistance_core_test.sv
